// ===== rtl/aaepb_pkg.sv =====
// shared constants and types for the anti-aliased ellipse pixel blend unit
package aaepb_pkg;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] REG_CENTER_X  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_CENTER_Y  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_SEMI_AX_H = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_SEMI_AX_V = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_FILL      = 3'd4;

   // register and field widths
   localparam int CENTER_W = 11;
   localparam int AXIS_W   = 9;
   localparam int AXIS2_W  = 2 * AXIS_W;
   localparam int COLOR_W  = 16;
   localparam int COV_W    = 5;
   localparam int FRAC_W   = 8;

   // result word: new_color, write_enable, coverage_count, zero pad to bytes
   localparam int RSP_W     = ((COLOR_W + 1 + COV_W + 7) / 8) * 8;
   localparam int RSP_PAD_W = RSP_W - COLOR_W - 1 - COV_W;

   typedef struct packed {
      logic [4:0] red;
      logic [5:0] green;
      logic [4:0] blue;
   } rgb565_type;

endpackage

// ===== rtl/antialiased_ellipse_pixel_blend_unit.sv =====
// anti-aliased ellipse fill: supersampled coverage and rgb565 blend, six-stage pipeline
// an accepted word is registered in each stage in turn, and the stage 6 register drives rsp_
// throughput: one pixel per clock while rsp_tready is high; the stages stall one by one, so bubbles fill in
// the squaring and scaling multipliers per subsample column and row set the stage cut
// reset: synchronous, clears all stage valid bits, center 0,0, semi-axes 1, fill 0
// the coverage compare of every subsample happens in parallel in stage four
module antialiased_ellipse_pixel_blend_unit #(
   parameter int COORD_BITS          = 10,
   parameter int SUBSAMPLES_PER_AXIS = 4
) (
   input  logic                                          clock,
   input  logic                                          reset,
   // configuration writes
   input  logic                                          csr_we,
   input  logic [aaepb_pkg::CSR_ADDR_W-1:0]              csr_addr,
   input  logic [aaepb_pkg::CSR_DATA_W-1:0]              csr_wdata,
   // pixel words in
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   // pixel_x, pixel_y, existing_color, zero pad
   input  logic [((2*COORD_BITS+16+7)/8)*8-1:0]          req_tdata,
   // results out
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   // new_color, write_enable, coverage_count, zero pad
   output logic [aaepb_pkg::RSP_W-1:0]                   rsp_tdata
);

   localparam int S      = SUBSAMPLES_PER_AXIS;
   localparam int SQ     = S * S;
   localparam int CNT_W  = $clog2(SQ + 1);
   localparam int IDX_W  = $clog2(SQ);
   localparam int ROW_W  = $clog2(S + 1);
   localparam int DX_W   = ((COORD_BITS > aaepb_pkg::CENTER_W) ?
                            COORD_BITS : aaepb_pkg::CENTER_W) + 2;
   localparam int M_W    = DX_W + $clog2(2 * S);
   localparam int MS_W   = M_W + 1;
   localparam int SQR_W  = 2 * M_W;
   localparam int T_W    = SQR_W + aaepb_pkg::AXIS2_W;
   localparam int AB_W   = 2 * aaepb_pkg::AXIS2_W;
   localparam int LIM_W  = AB_W + $clog2(4 * SQ + 1);
   localparam int CMP_W  = ((T_W + 1) > LIM_W) ? (T_W + 1) : LIM_W;
   localparam int NST    = 6;

   localparam logic signed [MS_W-1:0] TWO_S = MS_W'(2 * S);

   // ---------------- configuration registers ----------------
   logic signed [aaepb_pkg::CENTER_W-1:0] cx_ff, cy_ff;
   logic [aaepb_pkg::AXIS_W-1:0]          sa_ff, sb_ff;
   logic [aaepb_pkg::COLOR_W-1:0]         fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff   <= '0;
         cy_ff   <= '0;
         sa_ff   <= aaepb_pkg::AXIS_W'(1);
         sb_ff   <= aaepb_pkg::AXIS_W'(1);
         fill_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            aaepb_pkg::REG_CENTER_X:  cx_ff   <= csr_wdata[aaepb_pkg::CENTER_W-1:0];
            aaepb_pkg::REG_CENTER_Y:  cy_ff   <= csr_wdata[aaepb_pkg::CENTER_W-1:0];
            aaepb_pkg::REG_SEMI_AX_H: sa_ff   <= csr_wdata[aaepb_pkg::AXIS_W-1:0];
            aaepb_pkg::REG_SEMI_AX_V: sb_ff   <= csr_wdata[aaepb_pkg::AXIS_W-1:0];
            aaepb_pkg::REG_FILL:      fill_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- stage valid chain ----------------
   logic [NST:1]   vld_ff;
   logic [NST:1]   vld_in;
   logic [NST+1:1] adv;

   always_comb begin
      adv[NST+1] = rsp_tready;
      for (int k = NST; k >= 1; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign vld_in = {vld_ff[NST-1:1], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 1; k <= NST; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   assign req_tready = adv[1];
   assign rsp_tvalid = vld_ff[NST];

   // ---------------- stage 1: offsets and squared semi-axes ----------------
   logic [COORD_BITS-1:0]            px, py;
   logic [aaepb_pkg::COLOR_W-1:0]    ex_word;
   logic [aaepb_pkg::AXIS_W-1:0]     a_cl, b_cl;
   logic signed [DX_W-1:0]           dx_ff, dy_ff;
   logic [aaepb_pkg::AXIS2_W-1:0]    a2_ff, b2_ff;
   logic [aaepb_pkg::COLOR_W-1:0]    ex1_ff;

   assign px      = req_tdata[COORD_BITS-1:0];
   assign py      = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign ex_word = req_tdata[2*COORD_BITS+aaepb_pkg::COLOR_W-1:2*COORD_BITS];
   // a zero semi-axis counts as one
   assign a_cl = (sa_ff == '0) ? aaepb_pkg::AXIS_W'(1) : sa_ff;
   assign b_cl = (sb_ff == '0) ? aaepb_pkg::AXIS_W'(1) : sb_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         dx_ff  <= $signed(DX_W'(px)) - DX_W'(cx_ff);
         dy_ff  <= $signed(DX_W'(py)) - DX_W'(cy_ff);
         a2_ff  <= aaepb_pkg::AXIS2_W'(a_cl) * aaepb_pkg::AXIS2_W'(a_cl);
         b2_ff  <= aaepb_pkg::AXIS2_W'(b_cl) * aaepb_pkg::AXIS2_W'(b_cl);
         ex1_ff <= ex_word;
      end
   end

   // ---------------- stage 2: squared subsample distances ----------------
   logic signed [MS_W-1:0]           msx [S];
   logic signed [MS_W-1:0]           msy [S];
   logic [M_W-1:0]                   mgx [S];
   logic [M_W-1:0]                   mgy [S];
   logic [SQR_W-1:0]                 mx2_ff [S];
   logic [SQR_W-1:0]                 my2_ff [S];
   logic [AB_W-1:0]                  ab2_ff;
   logic [aaepb_pkg::AXIS2_W-1:0]    a2b_ff, b2b_ff;
   logic [aaepb_pkg::COLOR_W-1:0]    ex2_ff;

   always_comb begin
      for (int i = 0; i < S; i++) begin
         msx[i] = MS_W'(dx_ff) * TWO_S + MS_W'(2 * i + 1);
         msy[i] = MS_W'(dy_ff) * TWO_S + MS_W'(2 * i + 1);
         mgx[i] = msx[i][MS_W-1] ? M_W'(-msx[i]) : M_W'(msx[i]);
         mgy[i] = msy[i][MS_W-1] ? M_W'(-msy[i]) : M_W'(msy[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         for (int i = 0; i < S; i++) begin
            mx2_ff[i] <= SQR_W'(mgx[i]) * SQR_W'(mgx[i]);
            my2_ff[i] <= SQR_W'(mgy[i]) * SQR_W'(mgy[i]);
         end
         ab2_ff <= AB_W'(a2_ff) * AB_W'(b2_ff);
         a2b_ff <= a2_ff;
         b2b_ff <= b2_ff;
         ex2_ff <= ex1_ff;
      end
   end

   // ---------------- stage 3: scale by the other axis ----------------
   logic [T_W-1:0]                   tx_ff [S];
   logic [T_W-1:0]                   ty_ff [S];
   logic [LIM_W-1:0]                 lim_ff;
   logic [aaepb_pkg::COLOR_W-1:0]    ex3_ff;

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         for (int i = 0; i < S; i++) begin
            tx_ff[i] <= T_W'(mx2_ff[i]) * T_W'(b2b_ff);
            ty_ff[i] <= T_W'(my2_ff[i]) * T_W'(a2b_ff);
         end
         lim_ff <= LIM_W'(ab2_ff) * LIM_W'(4 * SQ);
         ex3_ff <= ex2_ff;
      end
   end

   // ---------------- stage 4: inside test, counted per row ----------------
   logic [ROW_W-1:0]                 row_in [S];
   logic [ROW_W-1:0]                 row_ff [S];
   logic [aaepb_pkg::COLOR_W-1:0]    ex4_ff;

   always_comb begin
      for (int j = 0; j < S; j++) begin
         row_in[j] = '0;
         for (int i = 0; i < S; i++) begin
            if (CMP_W'(tx_ff[i]) + CMP_W'(ty_ff[j]) <= CMP_W'(lim_ff)) begin
               row_in[j] = row_in[j] + ROW_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         row_ff <= row_in;
         ex4_ff <= ex3_ff;
      end
   end

   // ---------------- stage 5: total coverage ----------------
   logic [CNT_W-1:0]                 cnt_in;
   logic [CNT_W-1:0]                 cnt_ff;
   logic [aaepb_pkg::COLOR_W-1:0]    ex5_ff;

   always_comb begin
      cnt_in = '0;
      for (int j = 0; j < S; j++) begin
         cnt_in = cnt_in + CNT_W'(row_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         cnt_ff <= cnt_in;
         ex5_ff <= ex4_ff;
      end
   end

   // ---------------- stage 6: blend and result register ----------------
   // blend weight out of 256 for each partial count
   logic [aaepb_pkg::FRAC_W-1:0] f_tab [SQ];

   for (genvar k = 0; k < SQ; k++) begin : g_ftab
      assign f_tab[k] = aaepb_pkg::FRAC_W'((k * 256) / SQ);
   end

   // e + floor((c - e) * f / 256), low bits kept by the caller
   function automatic logic [5:0] blend_chan(input logic [5:0] e,
                                             input logic [5:0] c,
                                             input logic [7:0] f);
      logic signed [6:0]  diff;
      logic signed [15:0] prod;
      logic signed [15:0] sum;
      diff = $signed({1'b0, c}) - $signed({1'b0, e});
      prod = 16'(diff) * $signed({8'd0, f});
      sum  = $signed({10'd0, e}) + (prod >>> 8);
      return sum[5:0];
   endfunction

   aaepb_pkg::rgb565_type        ex_rgb, fill_rgb, blend_rgb;
   logic [aaepb_pkg::FRAC_W-1:0] frac;
   logic [5:0]                   bl_r, bl_g, bl_b;
   logic [aaepb_pkg::COLOR_W-1:0] color_in;
   logic [aaepb_pkg::COLOR_W-1:0] rsp_color_ff;
   logic                          rsp_we_ff;
   logic [CNT_W-1:0]              rsp_cnt_ff;

   assign ex_rgb   = aaepb_pkg::rgb565_type'(ex5_ff);
   assign fill_rgb = aaepb_pkg::rgb565_type'(fill_ff);
   assign frac     = f_tab[cnt_ff[IDX_W-1:0]];
   assign bl_r     = blend_chan({1'b0, ex_rgb.red},  {1'b0, fill_rgb.red},  frac);
   assign bl_g     = blend_chan(ex_rgb.green,        fill_rgb.green,        frac);
   assign bl_b     = blend_chan({1'b0, ex_rgb.blue}, {1'b0, fill_rgb.blue}, frac);

   always_comb begin
      blend_rgb.red   = bl_r[4:0];
      blend_rgb.green = bl_g;
      blend_rgb.blue  = bl_b[4:0];
      if (cnt_ff == '0) begin
         color_in = ex5_ff;
      end else if (cnt_ff == CNT_W'(SQ)) begin
         color_in = fill_ff;
      end else begin
         color_in = blend_rgb;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         rsp_color_ff <= color_in;
         rsp_we_ff    <= (cnt_ff != '0);
         rsp_cnt_ff   <= cnt_ff;
      end
   end

   assign rsp_tdata = {{aaepb_pkg::RSP_PAD_W{1'b0}},
                       aaepb_pkg::COV_W'(rsp_cnt_ff), rsp_we_ff, rsp_color_ff};

   // ---------------- assertions ----------------
   // words in flight change only through the two handshakes
   assert property (@(posedge clock) disable iff (reset)
      (!(req_tvalid && req_tready) && !(rsp_tvalid && rsp_tready))
      |=> ($countones(vld_ff) == $past($countones(vld_ff))))
      else $error("pipeline occupancy changed without a handshake");

   // input backpressure only when every stage holds a word
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (&vld_ff))
      else $error("input stalled while a stage is empty");

   // summed coverage never exceeds the subsample grid
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[5] |-> (cnt_ff <= CNT_W'(SQ)))
      else $error("coverage count beyond grid size");

endmodule

// ===== tb/antialiased_ellipse_pixel_blend_unit_test.sv =====
// testbench for the anti-aliased ellipse pixel blend unit: predicted coverage and blend checks
`timescale 1ns / 100ps

module antialiased_ellipse_pixel_blend_unit_test;

   localparam int COORD_BITS  = 10;
   localparam int SUBSAMPLES  = 4;
   localparam int REQ_W       = ((2 * COORD_BITS + aaepb_pkg::COLOR_W + 7) / 8) * 8;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [aaepb_pkg::COLOR_W-1:0] existing_color;
      logic [COORD_BITS-1:0]         pixel_y;
      logic [COORD_BITS-1:0]         pixel_x;
   } pixel_word_type;

   typedef struct packed {
      logic [aaepb_pkg::COV_W-1:0]   coverage_count;
      logic                          write_enable;
      logic [aaepb_pkg::COLOR_W-1:0] new_color;
   } shade_type;

   typedef struct {
      pixel_word_type pixel;
      shade_type      shade;
   } shade_entry_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             csr_we = 1'b0;
   logic [aaepb_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [aaepb_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   // pixel_x, pixel_y, existing_color, zero pad
   logic [REQ_W-1:0]                 req_tdata = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   // new_color, write_enable, coverage_count, zero pad
   logic [aaepb_pkg::RSP_W-1:0]      rsp_tdata;

   // local copy of the ellipse settings
   logic signed [aaepb_pkg::CENTER_W-1:0] ell_cx = '0;
   logic signed [aaepb_pkg::CENTER_W-1:0] ell_cy = '0;
   logic [aaepb_pkg::AXIS_W-1:0]          axis_h = 9'd1;
   logic [aaepb_pkg::AXIS_W-1:0]          axis_v = 9'd1;
   aaepb_pkg::rgb565_type                 fill_rgb = '0;

   pixel_word_type  pixel_queue[$];
   shade_entry_type shade_queue[$];
   int              mismatch_count = 0;
   int              cycle_count = 0;
   bit              steady_flow = 1'b0;

   pixel_word_type  sent_pixel;
   shade_entry_type want;
   shade_type       got;

   antialiased_ellipse_pixel_blend_unit #(
      .COORD_BITS          (COORD_BITS),
      .SUBSAMPLES_PER_AXIS (SUBSAMPLES)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // e + floor((c - e) * f / 256) via arithmetic shift, then masked
   function automatic longint blend_channel(longint e, longint c, longint f, int bits);
      longint d;
      d = (c - e) * f;
      return (e + (d >>> aaepb_pkg::FRAC_W)) & ((longint'(1) << bits) - 1);
   endfunction

   function automatic shade_type shade_pixel(pixel_word_type p);
      longint                a, b, a2, b2, limit, dx, dy, mx, my, ty, f;
      int                    cnt;
      aaepb_pkg::rgb565_type ex, mix;
      shade_type             r;
      a = (axis_h == 0) ? 1 : longint'(axis_h);
      b = (axis_v == 0) ? 1 : longint'(axis_v);
      a2 = a * a;
      b2 = b * b;
      limit = 4 * SUBSAMPLES * SUBSAMPLES * a2 * b2;
      dx = longint'(p.pixel_x) - longint'(ell_cx);
      dy = longint'(p.pixel_y) - longint'(ell_cy);
      cnt = 0;
      for (int j = 0; j < SUBSAMPLES; j++) begin
         my = 2 * SUBSAMPLES * dy + 2 * j + 1;
         if (my < 0) my = -my;
         ty = my * my * a2;
         for (int i = 0; i < SUBSAMPLES; i++) begin
            mx = 2 * SUBSAMPLES * dx + 2 * i + 1;
            if (mx < 0) mx = -mx;
            if (mx * mx * b2 + ty <= limit) cnt++;
         end
      end
      ex = aaepb_pkg::rgb565_type'(p.existing_color);
      if (cnt == 0) begin
         mix = ex;
      end else if (cnt >= SUBSAMPLES * SUBSAMPLES) begin
         mix = fill_rgb;
      end else begin
         f = (cnt * 256) / (SUBSAMPLES * SUBSAMPLES);
         mix.red   = 5'(blend_channel(ex.red, fill_rgb.red, f, 5));
         mix.green = 6'(blend_channel(ex.green, fill_rgb.green, f, 6));
         mix.blue  = 5'(blend_channel(ex.blue, fill_rgb.blue, f, 5));
      end
      r.new_color      = mix;
      r.write_enable   = (cnt > 0);
      r.coverage_count = aaepb_pkg::COV_W'(cnt);
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   // driver: pixel words from the pending queue
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            sent_pixel = pixel_word_type'(req_tdata[$bits(pixel_word_type)-1:0]);
            shade_queue.push_back('{pixel: sent_pixel, shade: shade_pixel(sent_pixel)});
         end
         if (!req_tvalid || req_tready) begin
            if (pixel_queue.size() != 0 && (steady_flow || $urandom_range(0, 99) >= 21)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= REQ_W'(pixel_queue.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each result word with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = shade_type'(rsp_tdata[$bits(shade_type)-1:0]);
            if (shade_queue.size() == 0) begin
               report_mismatch($sformatf("result word %h with nothing expected", got));
            end else begin
               want = shade_queue.pop_front();
               if (got.new_color !== want.shade.new_color)
                  report_mismatch($sformatf("pixel (%0d,%0d) new_color %h, want %h",
                     want.pixel.pixel_x, want.pixel.pixel_y, got.new_color,
                     want.shade.new_color));
               if (got.write_enable !== want.shade.write_enable)
                  report_mismatch($sformatf("pixel (%0d,%0d) write_enable %b, want %b",
                     want.pixel.pixel_x, want.pixel.pixel_y, got.write_enable,
                     want.shade.write_enable));
               if (got.coverage_count !== want.shade.coverage_count)
                  report_mismatch($sformatf("pixel (%0d,%0d) coverage_count %0d, want %0d",
                     want.pixel.pixel_x, want.pixel.pixel_y, got.coverage_count,
                     want.shade.coverage_count));
            end
         end
         rsp_tready <= steady_flow || ($urandom_range(0, 99) >= 21);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("antialiased_ellipse_pixel_blend_unit verification failed");
         $finish;
      end
   end

   task automatic wait_idle();
      while (pixel_queue.size() != 0 || req_tvalid || shade_queue.size() != 0)
         @(posedge clock);
   endtask

   // writes all five registers in consecutive cycles
   task automatic configure(int cx, int cy, int ah, int av, int fill);
      logic [aaepb_pkg::CSR_DATA_W-1:0] vals[5];
      logic [aaepb_pkg::CSR_ADDR_W-1:0] idxs[5];
      vals = '{16'(cx & 'h7FF), 16'(cy & 'h7FF), 16'(ah & 'h1FF), 16'(av & 'h1FF),
               16'(fill)};
      idxs = '{aaepb_pkg::REG_CENTER_X, aaepb_pkg::REG_CENTER_Y,
               aaepb_pkg::REG_SEMI_AX_H, aaepb_pkg::REG_SEMI_AX_V,
               aaepb_pkg::REG_FILL};
      for (int k = 0; k < 5; k++) begin
         csr_we    <= 1'b1;
         csr_addr  <= idxs[k];
         csr_wdata <= vals[k];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      ell_cx   = vals[0][aaepb_pkg::CENTER_W-1:0];
      ell_cy   = vals[1][aaepb_pkg::CENTER_W-1:0];
      axis_h   = vals[2][aaepb_pkg::AXIS_W-1:0];
      axis_v   = vals[3][aaepb_pkg::AXIS_W-1:0];
      fill_rgb = aaepb_pkg::rgb565_type'(vals[4]);
   endtask

   task automatic add_pixel(int x, int y, int color);
      pixel_word_type p;
      p.pixel_x        = COORD_BITS'(x);
      p.pixel_y        = COORD_BITS'(y);
      p.existing_color = aaepb_pkg::COLOR_W'(color);
      pixel_queue.push_back(p);
   endtask

   // mostly pixels around the current ellipse, the rest anywhere
   task automatic add_random_pixel();
      int ax, ay, x, y;
      ax = (axis_h == 0) ? 1 : int'(axis_h);
      ay = (axis_v == 0) ? 1 : int'(axis_v);
      if ($urandom_range(0, 3) != 0) begin
         x = int'(ell_cx) + int'($urandom_range(0, 2 * ax + 6)) - (ax + 3);
         y = int'(ell_cy) + int'($urandom_range(0, 2 * ay + 6)) - (ay + 3);
         if (x < 0) x = 0;
         if (x > 1023) x = 1023;
         if (y < 0) y = 0;
         if (y > 1023) y = 1023;
      end else begin
         x = $urandom_range(0, 1023);
         y = $urandom_range(0, 1023);
      end
      add_pixel(x, y, $urandom_range(0, 65535));
   endtask

   initial begin
      int cx, cy, ah, av, n;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // settings after reset: unit circle at the origin, black fill
      add_pixel(0, 0, 'h0000);
      add_pixel(0, 0, 'hFFFF);
      add_pixel(1, 1, 'h1234);
      add_pixel(1023, 1023, 'hFFFF);
      add_pixel(1023, 0, 'hA5A5);
      add_pixel(0, 1023, 'h5A5A);
      wait_idle();

      // most negative and most positive center, largest axes
      configure(-1024, 1023, 511, 511, 'hFFFF);
      add_pixel(0, 1023, 'h0000);
      add_pixel(0, 512, 'hFFFF);
      add_pixel(1023, 1023, 'h8421);
      wait_idle();

      // zero semi-axes act as one
      configure(1023, -1024, 0, 0, 'hF81F);
      add_pixel(1023, 0, 'h07E0);
      add_pixel(1022, 0, 'h1111);
      wait_idle();
      configure(1023, 0, 0, 0, 'hF81F);
      add_pixel(1023, 0, 'h07E0);
      add_pixel(1022, 0, 'h0000);
      add_pixel(1023, 1, 'hFFFF);
      wait_idle();

      // small ellipse: full, partial and empty pixels
      configure(100, 200, 3, 5, 'h07E0);
      add_pixel(100, 200, 'hF800);
      add_pixel(102, 201, 'h001F);
      add_pixel(103, 200, 'hFFFF);
      add_pixel(100, 205, 'h0000);
      add_pixel(97, 195, 'h7BEF);
      add_pixel(110, 200, 'h5555);
      wait_idle();

      for (int ph = 0; ph < 8; ph++) begin
         cx = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 2047)) - 1024
                                           : int'($urandom_range(0, 1023));
         cy = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 2047)) - 1024
                                           : int'($urandom_range(0, 1023));
         ah = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 24);
         av = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 24);
         configure(cx, cy, ah, av, $urandom_range(0, 65535));
         // one long phase runs without any idling
         steady_flow = (ph == 3);
         n = (ph == 3) ? 150 : 80;
         repeat (n) add_random_pixel();
         wait_idle();
         steady_flow = 1'b0;
      end

      repeat (12) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("antialiased_ellipse_pixel_blend_unit verification clean");
      end else begin
         $display("antialiased_ellipse_pixel_blend_unit verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/aaepb_pkg.sv
rtl/antialiased_ellipse_pixel_blend_unit.sv
tb/antialiased_ellipse_pixel_blend_unit_test.sv
